/* design/bucket_key_allocate_table_top_macros.svh */
// Assertion macros used by the checker file.
`ifndef BUCKET_KEY_ALLOCATE_TABLE_TOP_MACROS_SVH
`define BUCKET_KEY_ALLOCATE_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BKAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bkat assertion failed");

// Next-cycle implication, disabled while reset is held.
`define BKAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bkat assertion failed");

`endif

/* design/bkat_pkg.sv */
`default_nettype none
package bkat_pkg;

    // Table depth, fallback entry included
    localparam int MAX_BUCKETS = 64;

    // Field widths
    localparam int GEOM_W   = 2;
    localparam int MAT_W    = 4;
    localparam int LAYER_W  = 2;
    localparam int KEY_W    = 8;
    localparam int BUCKET_W = 6;
    localparam int STATUS_W = 3;
    localparam int CEIL_W   = 7;
    localparam int MASK_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef logic [GEOM_W-1:0]   t_geometry;
    typedef logic [MAT_W-1:0]    t_material;
    typedef logic [LAYER_W-1:0]  t_layer;
    typedef logic [KEY_W-1:0]    t_key;
    typedef logic [BUCKET_W-1:0] t_bucket;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [CEIL_W-1:0]   t_ceiling;
    typedef logic [MASK_W-1:0]   t_mask;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_index;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // Geometry codes
    localparam t_geometry GEOM_STATIC  = 2'd0;
    localparam t_geometry GEOM_SKINNED = 2'd1;
    localparam t_geometry GEOM_GRASS   = 2'd2;

    // Material codes
    localparam t_material MAT_INVALID = 4'd0;
    localparam t_material MAT_NULL    = 4'd1;
    localparam t_material MAT_ASSERT  = 4'd2;
    localparam t_material MAT_PBR     = 4'd3;

    // Layer codes
    localparam t_layer LAYER_OPAQUE  = 2'd0;
    localparam t_layer LAYER_BLEND   = 2'd1;
    localparam t_layer LAYER_INVALID = 2'd3;

    // Result status codes
    localparam t_status ST_HIT       = 3'd0;
    localparam t_status ST_ALLOC     = 3'd1;
    localparam t_status ST_FULL      = 3'd2;
    localparam t_status ST_BAD_MAT   = 3'd3;
    localparam t_status ST_BAD_LAYER = 3'd4;
    localparam t_status ST_GRASS     = 3'd5;
    localparam t_status ST_SKINNED   = 3'd6;

    // Configuration register indexes
    localparam t_cfg_index CFG_IDX_CEILING = 1'b0;
    localparam t_cfg_index CFG_IDX_MASK    = 1'b1;

    localparam t_ceiling CEILING_RESET = 7'd64;

    // Key of the fixed fallback entry: static, opaque, null material
    localparam t_key KEY_ENTRY0 = {GEOM_STATIC, LAYER_OPAQUE, MAT_NULL};

    // Classified request passed from front to back
    typedef struct packed {
        logic    err;
        t_status status;
        t_key    key;
        logic    blend;
    } t_req;

endpackage
`default_nettype wire

/* design/bkat_front.sv */
`default_nettype none
module bkat_front (
    input  wire bkat_pkg::t_geometry i_geometry,
    input  wire                      i_handle_valid,
    input  wire bkat_pkg::t_material i_material,
    input  wire bkat_pkg::t_layer    i_layer,
    input  wire bkat_pkg::t_mask     i_game_surface_mask,
    output bkat_pkg::t_req           o_req
);
    import bkat_pkg::*;

    t_material mat;
    t_layer    lay;
    logic      skin_refused;

    // Normalise: invalid handle or null/assert material forces opaque
    always_comb begin
        mat = i_handle_valid ? i_material : MAT_NULL;
        lay = i_handle_valid ? i_layer : LAYER_OPAQUE;
        if (mat == MAT_NULL || mat == MAT_ASSERT) begin
            lay = LAYER_OPAQUE;
        end
    end

    assign skin_refused = (i_geometry == GEOM_SKINNED) && (mat != MAT_PBR) &&
                          !i_game_surface_mask[mat];

    // Validate in priority order and build the lookup key
    always_comb begin
        o_req.err    = 1'b1;
        o_req.status = ST_HIT;
        o_req.key    = {i_geometry, lay, mat};
        o_req.blend  = (lay == LAYER_BLEND);
        if (mat == MAT_INVALID) begin
            o_req.status = ST_BAD_MAT;
        end else if (lay == LAYER_INVALID) begin
            o_req.status = ST_BAD_LAYER;
        end else if (i_geometry == GEOM_GRASS && lay != LAYER_OPAQUE) begin
            o_req.status = ST_GRASS;
        end else if (skin_refused) begin
            o_req.status = ST_SKINNED;
        end else begin
            o_req.err = 1'b0;
        end
    end

endmodule
`default_nettype wire

/* design/bkat_queue.sv */
`default_nettype none
module bkat_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  wire bkat_pkg::t_req i_req,
    input  wire            i_pop,
    output bkat_pkg::t_req o_req,
    output logic           o_full,
    output logic           o_empty
);
    import bkat_pkg::*;

    t_req       r_mem [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_req   = r_mem[r_rd_ptr];

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

/* design/bkat_ram.sv */
`default_nettype none
module bkat_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64
) (
    input  wire                       i_clk,
    input  wire                       i_wr_en,
    input  wire [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  wire [WIDTH-1:0]           i_wr_data,
    input  wire                       i_rd_en,
    input  wire [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [WIDTH-1:0]          o_rd_data
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

/* design/bkat_back.sv */
`default_nettype none
module bkat_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire bkat_pkg::t_req     i_req,
    input  wire                     i_req_empty,
    output logic                    o_pop,
    input  wire bkat_pkg::t_ceiling i_bucket_ceiling,
    output logic                    o_result_valid,
    output bkat_pkg::t_bucket       o_bucket,
    output logic                    o_transparent,
    output bkat_pkg::t_status       o_status
);
    import bkat_pkg::*;

    localparam int CW = $clog2(MAX_BUCKETS + 1);
    localparam int AW = $clog2(MAX_BUCKETS);
    localparam int EW = (CW > CEIL_W) ? CW : CEIL_W;
    localparam int RW = KEY_W + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic          r_state, n_state;
    logic [CW-1:0] r_used, n_used;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_pend_idx, n_pend_idx;
    logic          r_pend, n_pend;
    t_key          r_key, n_key;
    logic          r_blend, n_blend;
    logic          r_res_valid, n_res_valid;
    t_bucket       r_bucket, n_bucket;
    logic          r_transparent, n_transparent;
    t_status       r_status, n_status;

    logic          rd_en;
    logic          wr_en;
    logic [RW-1:0] rd_data;
    logic [EW-1:0] ceil_ext;
    logic [EW-1:0] ceil_eff;
    logic          full;

    // Key store: one entry read per cycle during a scan
    bkat_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_BUCKETS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_used[AW-1:0]),
        .i_wr_data ({r_blend, r_key}),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Clamp the ceiling into 1..MAX_BUCKETS
    always_comb begin
        ceil_ext = EW'(i_bucket_ceiling);
        if (ceil_ext == '0) begin
            ceil_eff = EW'(1);
        end else if (ceil_ext > EW'(MAX_BUCKETS)) begin
            ceil_eff = EW'(MAX_BUCKETS);
        end else begin
            ceil_eff = ceil_ext;
        end
    end

    assign full = (EW'(r_used) >= ceil_eff);

    // Scan sequencer: entry 0 by constant, entries 1..used-1 from the store
    always_comb begin
        n_state       = r_state;
        n_used        = r_used;
        n_rd_idx      = r_rd_idx;
        n_pend_idx    = r_pend_idx;
        n_pend        = r_pend;
        n_key         = r_key;
        n_blend       = r_blend;
        n_res_valid   = 1'b0;
        n_bucket      = r_bucket;
        n_transparent = r_transparent;
        n_status      = r_status;
        o_pop         = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_req_empty) begin
                    o_pop = 1'b1;
                    if (i_req.err) begin
                        n_res_valid   = 1'b1;
                        n_bucket      = '0;
                        n_transparent = 1'b0;
                        n_status      = i_req.status;
                    end else if (i_req.key == KEY_ENTRY0) begin
                        n_res_valid   = 1'b1;
                        n_bucket      = '0;
                        n_transparent = 1'b0;
                        n_status      = ST_HIT;
                    end else begin
                        n_key    = i_req.key;
                        n_blend  = i_req.blend;
                        n_rd_idx = CW'(1);
                        n_pend   = 1'b0;
                        n_state  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_pend && rd_data[KEY_W-1:0] == r_key) begin
                    // Hit on the entry read last cycle
                    n_res_valid   = 1'b1;
                    n_bucket      = BUCKET_W'(r_pend_idx);
                    n_transparent = rd_data[KEY_W];
                    n_status      = ST_HIT;
                    n_pend        = 1'b0;
                    n_state       = S_IDLE;
                end else if (r_rd_idx < r_used) begin
                    rd_en      = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_idx;
                    n_rd_idx   = r_rd_idx + CW'(1);
                end else begin
                    // Miss: allocate the next entry or fall back
                    n_res_valid = 1'b1;
                    n_pend      = 1'b0;
                    n_state     = S_IDLE;
                    if (full) begin
                        n_bucket      = '0;
                        n_transparent = 1'b0;
                        n_status      = ST_FULL;
                    end else begin
                        wr_en         = 1'b1;
                        n_used        = r_used + CW'(1);
                        n_bucket      = BUCKET_W'(r_used);
                        n_transparent = r_blend;
                        n_status      = ST_ALLOC;
                    end
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= CW'(1);
            r_pend      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_pend      <= n_pend;
            r_res_valid <= n_res_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx      <= n_rd_idx;
        r_pend_idx    <= n_pend_idx;
        r_key         <= n_key;
        r_blend       <= n_blend;
        r_bucket      <= n_bucket;
        r_transparent <= n_transparent;
        r_status      <= n_status;
    end

    assign o_result_valid = r_res_valid;
    assign o_bucket       = r_bucket;
    assign o_transparent  = r_transparent;
    assign o_status       = r_status;

endmodule
`default_nettype wire

/* design/bucket_key_allocate_table_top.sv */
// Bucket key allocate table. A request (geometry, handle valid, material,
// layer) is taken at a clock edge with i_start high and o_busy low, and
// exactly one result word comes back on o_bucket/o_transparent/o_status,
// marked by a one-cycle o_result_valid strobe that cannot be held off.
// Results return in request order. The front validates each request in the
// cycle it is taken and places it in a two-word queue; o_busy is high only
// while that queue is full. The back resolves one queued request at a time:
// a rejected request, or one for the fixed entry 0, gives its result when
// the back pops it from the queue, through the back's result register; any
// other request walks the stored keys through the single read port of the
// key store, one entry per cycle, ending on a hit or, after the last used
// entry, on a miss (allocation or full fallback). The store needs no
// clearing pass after reset. Write configuration only while no request is
// outstanding; o_cfg_ready is always high.
`default_nettype none
module bucket_key_allocate_table_top (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    output logic                      o_busy,
    input  wire bkat_pkg::t_geometry  i_geometry,
    input  wire                       i_handle_valid,
    input  wire bkat_pkg::t_material  i_material,
    input  wire bkat_pkg::t_layer     i_layer,
    output logic                      o_result_valid,
    output bkat_pkg::t_bucket         o_bucket,
    output logic                      o_transparent,
    output bkat_pkg::t_status         o_status,
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire bkat_pkg::t_cfg_index i_cfg_index,
    input  wire bkat_pkg::t_cfg_data  i_cfg_data
);
    import bkat_pkg::*;

    t_ceiling r_bucket_ceiling;
    t_mask    r_game_surface_mask;
    t_req     front_req;
    t_req     queue_req;
    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_empty;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = q_full;
    assign push        = i_start && !q_full;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_ceiling    <= CEILING_RESET;
            r_game_surface_mask <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDX_CEILING: r_bucket_ceiling    <= i_cfg_data[CEIL_W-1:0];
                CFG_IDX_MASK:    r_game_surface_mask <= i_cfg_data[MASK_W-1:0];
            endcase
        end
    end

    bkat_front u_front (
        .i_geometry          (i_geometry),
        .i_handle_valid      (i_handle_valid),
        .i_material          (i_material),
        .i_layer             (i_layer),
        .i_game_surface_mask (r_game_surface_mask),
        .o_req               (front_req)
    );

    bkat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .i_pop   (pop),
        .o_req   (queue_req),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    bkat_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (queue_req),
        .i_req_empty      (q_empty),
        .o_pop            (pop),
        .i_bucket_ceiling (r_bucket_ceiling),
        .o_result_valid   (o_result_valid),
        .o_bucket         (o_bucket),
        .o_transparent    (o_transparent),
        .o_status         (o_status)
    );

endmodule
`default_nettype wire

/* design/bkat_checker.sv */
`default_nettype none
`include "bucket_key_allocate_table_top_macros.svh"
module bkat_props (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      i_start,
    input wire                      o_busy,
    input wire                      o_result_valid,
    input wire bkat_pkg::t_bucket   o_bucket,
    input wire                      o_transparent,
    input wire bkat_pkg::t_status   o_status
);
    import bkat_pkg::*;

    logic rejected;
    logic fell_back;
    logic zero_word;

    // Classify the word on the result ports
    assign rejected  = o_result_valid &&
                       (o_status == ST_BAD_MAT || o_status == ST_BAD_LAYER ||
                        o_status == ST_GRASS || o_status == ST_SKINNED);
    assign fell_back = o_result_valid && (o_status == ST_FULL);
    assign zero_word = (o_bucket == '0) && !o_transparent;

    // Rejected requests return the opaque fallback
    `BKAT_ASSERT_NOW(a_error_fallback, i_clk, i_rst_n, rejected, zero_word)

    // A full table returns the opaque fallback
    `BKAT_ASSERT_NOW(a_full_fallback, i_clk, i_rst_n, fell_back, zero_word)

    // No status beyond the defined codes
    `BKAT_ASSERT_NOW(a_status_range, i_clk, i_rst_n, o_result_valid, o_status <= ST_SKINNED)

    // Busy cannot rise without a new request
    `BKAT_ASSERT_NEXT(a_busy_needs_start, i_clk, i_rst_n, !o_busy && !i_start, !o_busy)

endmodule

bind bucket_key_allocate_table_top bkat_props u_bkat_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_result_valid (o_result_valid),
    .o_bucket       (o_bucket),
    .o_transparent  (o_transparent),
    .o_status       (o_status)
);
`default_nettype wire
